[rtl/assert_macros.svh]
// Assertion macros shared by the walker RTL.
// Each macro expects signals named clk and arst_n in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FW_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/fat16w_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and helpers for the FAT16 cluster-chain walker.
// No dependencies; the other files of the walker refer to it by scoped names or import it.
package fat16w_pkg;

	// Cluster table geometry.
	localparam int TABLE_ENTRIES = 65536;
	localparam int TABLE_AW      = $clog2(TABLE_ENTRIES);

	// First cluster that maps into the data region.
	localparam logic [15:0] FIRST_DATA_CLUSTER = 16'd2;

	// Limits on sectors per cluster.
	localparam logic [7:0] SPC_MIN = 8'd1;
	localparam logic [7:0] SPC_MAX = 8'd128;

	// Item modes.
	typedef enum logic [1:0] {
		MODE_LOAD  = 2'd0,
		MODE_START = 2'd1,
		MODE_NEXT  = 2'd2
	} mode_t;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_DATA_OFFSET  = 3'd0,
		REG_SPC          = 3'd1,
		REG_SECTOR_BYTES = 3'd2,
		REG_FREE_MARK    = 3'd3,
		REG_END_MARK     = 3'd4,
		REG_BAD_MARK     = 3'd5,
		REG_RSV_MARK     = 3'd6
	} reg_idx_t;

	// Input item.
	typedef struct packed {
		logic [1:0]  mode;
		logic [15:0] table_index;
		logic [15:0] table_value;
		logic [15:0] first_cluster;
		logic [31:0] file_length;
	} in_item_t;

	// Result item.
	typedef struct packed {
		logic [31:0] sector_address;
		logic        address_valid;
		logic        transfer_done;
	} out_item_t;

	// Table write request.
	typedef struct packed {
		logic        en;
		logic [15:0] idx;
		logic [15:0] val;
	} tbl_wr_t;

	// Table read request and response.
	typedef struct packed {
		logic        en;
		logic [15:0] idx;
	} tbl_rq_t;

	typedef struct packed {
		logic [15:0] data;
		logic        ok;
	} tbl_rd_t;

	// Clamp sectors per cluster into the supported range.
	function automatic logic [7:0] eff_spc(input logic [7:0] spc);
		logic [7:0] r;
		if (spc < SPC_MIN) begin
			r = SPC_MIN;
		end else if (spc > SPC_MAX) begin
			r = SPC_MAX;
		end else begin
			r = spc;
		end
		return r;
	endfunction

endpackage

[rtl/fat16w_chan_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the walker's input and result items.
// Depends on fat16w_pkg for the payload types.

// Channel that carries input items.
interface fat16w_in_if;
	logic                 valid;
	logic                 ready;
	fat16w_pkg::in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// Channel that carries result items.
interface fat16w_out_if;
	logic                  valid;
	logic                  ready;
	fat16w_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/fat16_chain_sector_walker_core.sv]
`timescale 1ns / 1ps
// Top level of the FAT16 cluster-chain sector walker.
// Depends on fat16w_pkg, fat16w_chan_if.sv, fat16w_table and assert_macros.svh.
//
//   port        dir   kind          item
//   cmd         in    valid/ready   load, start or next command
//   rsp         out   valid/ready   sector address with valid and done flags
//   cfg_*       in    write only    seven configuration registers
//
// A load or unused-mode item stays in the idle step; a start item, or a next item that
// moves on, goes through accept, check, multiply and add (a next item reads the table at
// accept). A next item that ends the transfer or arrives while idle goes through
// accept and check. Reset clears control state at once; the table stays undefined
// until loaded, so there is no clearing pass. A full result register holds the
// sequencer in its check or add step until rsp takes the item.
`include "assert_macros.svh"

module fat16_chain_sector_walker_core (
	input  logic        clk,
	input  logic        arst_n,
	fat16w_in_if.sink   cmd,
	fat16w_out_if.source rsp,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [31:0] cfg_wdata
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_CHECK = 4'b0010,
		ST_MUL   = 4'b0100,
		ST_SUM   = 4'b1000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [31:0] data_offset_q;
	logic [7:0]  spc_q;
	logic [12:0] sb_q;
	logic [15:0] free_q;
	logic [15:0] end_q;
	logic [15:0] bad_q;
	logic [15:0] rsv_q;

	// Transfer state.
	logic        active_q;
	logic [6:0]  sector_q;
	logic [15:0] cur_cluster_q;
	logic [31:0] cur_addr_q;
	logic [31:0] bytes_q;
	logic [15:0] start_q;
	logic [31:0] size_q;

	// Per-item flags and payload.
	logic        is_start_q;
	logic        idle_next_q;
	logic        bnd_q;
	logic [31:0] ret_addr_q;

	// Address pipeline.
	logic [20:0] pc_s1;
	logic [19:0] ss_s1;
	logic [31:0] cm2_s1;
	logic [31:0] prod_s2;
	logic [31:0] off_s2;

	// Result register.
	logic                  rsp_valid_q;
	fat16w_pkg::out_item_t rsp_q;

	logic                  cmd_fire;
	logic [7:0]            spc_eff;
	logic                  boundary;
	logic [32:0]           bytes_sum;
	logic [31:0]           bytes_sat;
	logic [15:0]           tbl_val;
	logic                  mark_hit;
	logic                  done_chk;
	logic [15:0]           clu_sel;
	logic                  out_free;
	logic                  want_emit;
	logic                  out_load;
	logic                  stall;
	fat16w_pkg::out_item_t out_d;
	fat16w_pkg::tbl_wr_t   tbl_wr;
	fat16w_pkg::tbl_rq_t   tbl_rq;
	fat16w_pkg::tbl_rd_t   tbl_rd;

	// Cluster table.
	fat16w_table u_table (
		.clk (clk),
		.wr  (tbl_wr),
		.rq  (tbl_rq),
		.rd  (tbl_rd)
	);

	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_fire  = cmd.valid && cmd.ready;

	// Table access: loads write at once, next items fetch the link of the current cluster.
	assign tbl_wr.en  = cmd_fire && (cmd.data.mode == fat16w_pkg::MODE_LOAD);
	assign tbl_wr.idx = cmd.data.table_index;
	assign tbl_wr.val = cmd.data.table_value;
	assign tbl_rq.en  = cmd_fire && (cmd.data.mode == fat16w_pkg::MODE_NEXT);
	assign tbl_rq.idx = cur_cluster_q;

	// Sector step and saturating byte count.
	assign spc_eff   = fat16w_pkg::eff_spc(spc_q);
	assign boundary  = (({1'b0, sector_q} + 8'd1) >= spc_eff);
	assign bytes_sum = {1'b0, bytes_q} + {20'd0, sb_q};
	assign bytes_sat = bytes_sum[32] ? 32'hFFFF_FFFF : bytes_sum[31:0];

	// End-of-chain and size checks; a link past the table reads as the end mark.
	assign tbl_val  = tbl_rd.ok ? tbl_rd.data : end_q;
	assign mark_hit = bnd_q && ((tbl_val == free_q) || (tbl_val == end_q) ||
		(tbl_val == bad_q) || (tbl_val == rsv_q));
	assign done_chk = !is_start_q && (mark_hit || (bytes_q >= size_q));
	assign clu_sel  = bnd_q ? tbl_val : cur_cluster_q;

	// Result emission and stall toward the result register.
	assign out_free = !rsp_valid_q || rsp.ready;

	always_comb begin
		want_emit = 1'b0;
		out_d     = '0;
		unique case (state_q)
			ST_CHECK: begin
				if (idle_next_q) begin
					want_emit = 1'b1;
				end else if (done_chk) begin
					want_emit            = 1'b1;
					out_d.sector_address = ret_addr_q;
					out_d.address_valid  = 1'b1;
					out_d.transfer_done  = 1'b1;
				end
			end
			ST_SUM: begin
				if (!is_start_q) begin
					want_emit            = 1'b1;
					out_d.sector_address = ret_addr_q;
					out_d.address_valid  = 1'b1;
				end
			end
			default: begin
				want_emit = 1'b0;
			end
		endcase
	end

	assign out_load = want_emit && out_free;
	assign stall    = want_emit && !out_free;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_offset_q <= 32'd0;
			spc_q         <= 8'd4;
			sb_q          <= 13'd512;
			free_q        <= 16'h0000;
			end_q         <= 16'hFFFF;
			bad_q         <= 16'hFFF7;
			rsv_q         <= 16'hFFF0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				fat16w_pkg::REG_DATA_OFFSET:  data_offset_q <= cfg_wdata;
				fat16w_pkg::REG_SPC:          spc_q         <= cfg_wdata[7:0];
				fat16w_pkg::REG_SECTOR_BYTES: sb_q          <= cfg_wdata[12:0];
				fat16w_pkg::REG_FREE_MARK:    free_q        <= cfg_wdata[15:0];
				fat16w_pkg::REG_END_MARK:     end_q         <= cfg_wdata[15:0];
				fat16w_pkg::REG_BAD_MARK:     bad_q         <= cfg_wdata[15:0];
				fat16w_pkg::REG_RSV_MARK:     rsv_q         <= cfg_wdata[15:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer and transfer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			active_q      <= 1'b0;
			sector_q      <= '0;
			cur_cluster_q <= '0;
			cur_addr_q    <= '0;
			bytes_q       <= '0;
			start_q       <= '0;
			size_q        <= '0;
			is_start_q    <= 1'b0;
			idle_next_q   <= 1'b0;
			bnd_q         <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_fire) begin
						case (cmd.data.mode)
							fat16w_pkg::MODE_START: begin
								start_q       <= cmd.data.first_cluster;
								size_q        <= cmd.data.file_length;
								active_q      <= 1'b1;
								sector_q      <= '0;
								cur_cluster_q <= cmd.data.first_cluster;
								bytes_q       <= '0;
								is_start_q    <= 1'b1;
								idle_next_q   <= 1'b0;
								bnd_q         <= 1'b0;
								state_q       <= ST_CHECK;
							end
							fat16w_pkg::MODE_NEXT: begin
								is_start_q  <= 1'b0;
								idle_next_q <= !active_q;
								bnd_q       <= active_q && boundary;
								if (active_q) begin
									bytes_q  <= bytes_sat;
									sector_q <= boundary ? 7'd0 : (sector_q + 7'd1);
								end
								state_q <= ST_CHECK;
							end
							default: begin
							end
						endcase
					end
				end
				ST_CHECK: begin
					if (!stall) begin
						if (idle_next_q) begin
							state_q <= ST_IDLE;
						end else if (done_chk) begin
							active_q      <= 1'b0;
							sector_q      <= '0;
							cur_cluster_q <= start_q;
							cur_addr_q    <= '0;
							bytes_q       <= '0;
							state_q       <= ST_IDLE;
						end else begin
							cur_cluster_q <= clu_sel;
							state_q       <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					if (!stall) begin
						cur_addr_q <= prod_s2 + off_s2;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Address pipeline: bytes per cluster and sector offset, then the cluster product.
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			ret_addr_q <= cur_addr_q;
		end
		if (state_q == ST_CHECK) begin
			pc_s1  <= {13'd0, spc_eff} * {8'd0, sb_q};
			ss_s1  <= {13'd0, sector_q} * {7'd0, sb_q};
			cm2_s1 <= {16'd0, clu_sel} - {16'd0, fat16w_pkg::FIRST_DATA_CLUSTER};
		end
		if (state_q == ST_MUL) begin
			prod_s2 <= cm2_s1 * {11'd0, pc_s1};
			off_s2  <= data_offset_q + {12'd0, ss_s1};
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rsp_q <= out_d;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	// Checks on the sequencer and transfer state.
	`FW_ASSERT_NEXT(a_done_clears, out_load && out_d.transfer_done,
		!active_q && (bytes_q == '0), "transfer end did not clear state")
	`FW_ASSERT_NOW(a_idle_result_zero, rsp_valid_q && !rsp_q.address_valid,
		(rsp_q.sector_address == '0) && !rsp_q.transfer_done, "idle result carries data")
	`FW_ASSERT_NOW(a_sum_after_mul, state_q == ST_SUM,
		($past(state_q) == ST_MUL) || ($past(state_q) == ST_SUM),
		"add step entered out of order")
	`FW_ASSERT_NEXT(a_start_arms, cmd_fire && (cmd.data.mode == fat16w_pkg::MODE_START),
		active_q && (sector_q == '0), "start item did not arm the transfer")

endmodule

[rtl/fat16w_table.sv]
`timescale 1ns / 1ps
// Cluster table memory: one write port and one read port with registered read data.
// Depends on fat16w_pkg for geometry and request types.
module fat16w_table (
	input  logic                clk,
	input  fat16w_pkg::tbl_wr_t wr,
	input  fat16w_pkg::tbl_rq_t rq,
	output fat16w_pkg::tbl_rd_t rd
);

	logic [15:0] mem [fat16w_pkg::TABLE_ENTRIES];
	logic        wr_hit;
	logic        rd_hit;
	logic [15:0] rdata_q;
	logic        rok_q;

	// Indexes past the end of the table are not stored.
	assign wr_hit = ({1'b0, wr.idx} < 17'(fat16w_pkg::TABLE_ENTRIES));
	assign rd_hit = ({1'b0, rq.idx} < 17'(fat16w_pkg::TABLE_ENTRIES));

	// Write port.
	always_ff @(posedge clk) begin
		if (wr.en && wr_hit) begin
			mem[wr.idx[fat16w_pkg::TABLE_AW-1:0]] <= wr.val;
		end
	end

	// Read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (rq.en) begin
			rdata_q <= mem[rq.idx[fat16w_pkg::TABLE_AW-1:0]];
			rok_q   <= rd_hit;
		end
	end

	assign rd.data = rdata_q;
	assign rd.ok   = rok_q;

endmodule

[tb/fat16w_walk_checker.sv]
`timescale 1ns / 1ps
// Checker for the FAT16 cluster-chain walker: follows configuration writes and command
// items, predicts each sector result and compares it with the result channel.
// Depends on fat16w_pkg for the item types, mode codes and register indexes.
module fat16w_walk_checker (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	input  logic                  cmd_ready,
	input  fat16w_pkg::in_item_t  cmd_item,
	input  logic                  rsp_valid,
	input  logic                  rsp_ready,
	input  fat16w_pkg::out_item_t rsp_item,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_idx,
	input  logic [31:0]           cfg_wdata,
	output int                    mismatches,
	output int                    outstanding
);
	import fat16w_pkg::*;

	// Mismatch lines beyond this count are counted but not printed.
	localparam int PRINT_LIMIT = 100;

	// Shadow of the cluster table and the configuration registers.
	logic [15:0] fat [TABLE_ENTRIES];
	logic [31:0] data_base;
	logic [7:0]  spc_raw;
	logic [12:0] sec_bytes;
	logic [15:0] mark_free;
	logic [15:0] mark_end;
	logic [15:0] mark_bad;
	logic [15:0] mark_rsv;

	// Walk state of the current file.
	logic        walking;
	logic [6:0]  sec_idx;
	logic [15:0] cur_clu;
	logic [31:0] cur_addr;
	logic [31:0] consumed;
	logic [15:0] start_clu;
	logic [31:0] size_lim;

	// Sector results predicted but not yet seen on the result channel.
	out_item_t sector_expect_q[$];
	int        err_total = 0;

	assign mismatches = err_total;

	// Sectors per cluster as the block uses them: zero reads as one, large values clamp.
	function automatic logic [7:0] spc_used();
		if (spc_raw < SPC_MIN) return SPC_MIN;
		if (spc_raw > SPC_MAX) return SPC_MAX;
		return spc_raw;
	endfunction

	// Byte address of a sector; all arithmetic wraps at 32 bits.
	function automatic logic [31:0] sector_addr(input logic [15:0] clu, input logic [6:0] sec);
		logic [31:0] span;
		span = 32'(spc_used()) * 32'(sec_bytes);
		return data_base + (32'(clu) - 32'(FIRST_DATA_CLUSTER)) * span
			+ 32'(sec) * 32'(sec_bytes);
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		if (err_total < PRINT_LIMIT) begin
			$display("%0t walk check: %s got %h expected %h", $time, what, got, want);
		end
		err_total++;
	endtask

	task automatic apply_reg(input logic [2:0] idx, input logic [31:0] val);
		case (reg_idx_t'(idx))
			REG_DATA_OFFSET:  data_base = val;
			REG_SPC:          spc_raw = val[7:0];
			REG_SECTOR_BYTES: sec_bytes = val[12:0];
			REG_FREE_MARK:    mark_free = val[15:0];
			REG_END_MARK:     mark_end = val[15:0];
			REG_BAD_MARK:     mark_bad = val[15:0];
			REG_RSV_MARK:     mark_rsv = val[15:0];
			default: ;
		endcase
	endtask

	// Advance the walk by one command item and queue the sector result it produces.
	task automatic take_item(input in_item_t it);
		out_item_t   res;
		logic [15:0] link;
		logic        finish;
		res = '0;
		finish = 1'b0;
		case (mode_t'(it.mode))
			MODE_LOAD: begin
				fat[it.table_index] = it.table_value;
			end
			MODE_START: begin
				start_clu = it.first_cluster;
				size_lim = it.file_length;
				walking = 1'b1;
				sec_idx = '0;
				cur_clu = it.first_cluster;
				consumed = '0;
				cur_addr = sector_addr(it.first_cluster, 7'd0);
			end
			MODE_NEXT: begin
				if (walking) begin
					res.sector_address = cur_addr;
					res.address_valid = 1'b1;
					// The byte count saturates instead of wrapping.
					if (consumed > 32'hFFFF_FFFF - 32'(sec_bytes)) begin
						consumed = '1;
					end else begin
						consumed = consumed + 32'(sec_bytes);
					end
					// At the last sector of a cluster, follow the table link.
					if (32'(sec_idx) + 32'd1 >= 32'(spc_used())) begin
						link = fat[cur_clu];
						sec_idx = '0;
						cur_clu = link;
						if (link == mark_free || link == mark_end || link == mark_bad ||
							link == mark_rsv) begin
							finish = 1'b1;
						end
					end else begin
						sec_idx = sec_idx + 7'd1;
					end
					// The file size is checked on every sector.
					if (consumed >= size_lim) finish = 1'b1;
					if (finish) begin
						walking = 1'b0;
						sec_idx = '0;
						cur_clu = start_clu;
						cur_addr = '0;
						consumed = '0;
					end else begin
						cur_addr = sector_addr(cur_clu, sec_idx);
					end
					res.transfer_done = finish;
				end
				sector_expect_q = {sector_expect_q, res};
			end
			default: ;
		endcase
	endtask

	task automatic check_result(input out_item_t got);
		out_item_t want;
		if (sector_expect_q.size() == 0) begin
			report("result item with nothing expected, address", got.sector_address, '0);
			return;
		end
		want = sector_expect_q.pop_front();
		if (got.sector_address !== want.sector_address) begin
			report("sector_address", got.sector_address, want.sector_address);
		end
		if (got.address_valid !== want.address_valid) begin
			report("address_valid", 32'(got.address_valid), 32'(want.address_valid));
		end
		if (got.transfer_done !== want.transfer_done) begin
			report("transfer_done", 32'(got.transfer_done), 32'(want.transfer_done));
		end
	endtask

	// Sample both channels and the register port at each rising edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_base = '0;
			spc_raw = 8'd4;
			sec_bytes = 13'd512;
			mark_free = 16'h0000;
			mark_end = 16'hFFFF;
			mark_bad = 16'hFFF7;
			mark_rsv = 16'hFFF0;
			walking = 1'b0;
			sec_idx = '0;
			cur_clu = '0;
			cur_addr = '0;
			consumed = '0;
			start_clu = '0;
			size_lim = '0;
			sector_expect_q.delete();
			outstanding <= 0;
		end else begin
			if (cfg_we) apply_reg(cfg_idx, cfg_wdata);
			if (rsp_valid && rsp_ready) check_result(rsp_item);
			if (cmd_valid && cmd_ready) take_item(cmd_item);
			outstanding <= sector_expect_q.size();
		end
	end
endmodule

[tb/fat16_chain_sector_walker_core_test.sv]
`timescale 1ns / 1ps
// Top of the walker test: clock, reset, register settings and command stimulus.
// Depends on fat16w_pkg, the channel interfaces, the walker core and fat16w_walk_checker.
module fat16_chain_sector_walker_core_test;
	import fat16w_pkg::*;

	localparam int TOTAL_ITEMS   = 1250;
	localparam int SETTING_COUNT = 7;
	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_HOLD     = 300;
	localparam int MAX_NEXT_RUN  = 24;

	// Mode value that the block ignores.
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	// One full set of register values.
	typedef struct packed {
		logic [31:0] base;
		logic [7:0]  spc;
		logic [12:0] sbytes;
		logic [15:0] free_v;
		logic [15:0] end_v;
		logic [15:0] bad_v;
		logic [15:0] rsv_v;
	} walk_cfg_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_idx;
	logic [31:0] cfg_wdata;
	int          mismatches;
	int          outstanding;

	fat16w_in_if  cmd_ch ();
	fat16w_out_if rsp_ch ();

	// Idle rates, long-stall requests and the count of accepted items.
	int tx_idle_pct   = 8;
	int rx_idle_pct   = 57;
	int hold_requests = 0;
	int accepted      = 0;

	// Table entries loaded so far; a walk may only reach these.
	bit          loaded [TABLE_ENTRIES];
	logic [15:0] shadow [TABLE_ENTRIES];
	logic [15:0] loaded_q[$];
	walk_cfg_t   cur_cfg;

	always #10 clk = ~clk;

	fat16_chain_sector_walker_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	fat16w_walk_checker walk_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_ch.valid),
		.cmd_ready   (cmd_ch.ready),
		.cmd_item    (cmd_ch.data),
		.rsp_valid   (rsp_ch.valid),
		.rsp_ready   (rsp_ch.ready),
		.rsp_item    (rsp_ch.data),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_wdata   (cfg_wdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// Result side: random stalls, plus a long hold-off whenever one is requested.
	initial begin
		int held;
		int seen_hold;
		held = 0;
		seen_hold = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_requests != seen_hold) begin
				seen_hold = hold_requests;
				held = LONG_HOLD;
			end
			if (held > 0) begin
				held--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// Hard stop in case the block hangs or a result never arrives.
	initial begin
		#10_000_000;
		$display("fat16_chain_sector_walker_core_test: done, errors");
		$finish;
	end

	function automatic walk_cfg_t setting_for(input int p);
		walk_cfg_t c;
		c = '{base: 32'd0, spc: 8'd4, sbytes: 13'd512, free_v: 16'h0000,
			end_v: 16'hFFFF, bad_v: 16'hFFF7, rsv_v: 16'hFFF0};
		case (p)
			0: c.spc = 8'd1;
			1: begin
				c.base = 32'h0010_0000;
				c.spc = 8'd2;
			end
			2: begin
				c.base = 32'hFFFF_FFFF;
				c.spc = 8'd0;
				c.sbytes = 13'd4096;
				c.free_v = 16'hFFFF;
				c.end_v = 16'h0000;
				c.bad_v = 16'h0001;
				c.rsv_v = 16'h0002;
			end
			3: begin
				c.base = 32'h8000_0000;
				c.spc = 8'd255;
				c.sbytes = 13'h1FFF;
				c.free_v = 16'h1234;
				c.end_v = 16'hAAAA;
				c.bad_v = 16'h5555;
			end
			4: begin
				c.base = 32'h1357_9BDF;
				c.spc = 8'd3;
				c.sbytes = 13'd0;
				c.free_v = 16'h0007;
				c.end_v = 16'h0007;
				c.bad_v = 16'h0007;
				c.rsv_v = 16'h0007;
			end
			5: begin
				c.base = 32'hFFFF_F000;
				c.spc = 8'd128;
				c.sbytes = 13'd1024;
				c.free_v = 16'hFFFF;
				c.end_v = 16'hFFF7;
				c.bad_v = 16'hFFF0;
				c.rsv_v = 16'h0000;
			end
			default: ;
		endcase
		return c;
	endfunction

	function automatic int spc_eff();
		if (cur_cfg.spc == 8'd0) return 1;
		if (cur_cfg.spc > 8'd128) return 128;
		return int'(cur_cfg.spc);
	endfunction

	function automatic bit is_mark(input logic [15:0] v);
		return v == cur_cfg.free_v || v == cur_cfg.end_v || v == cur_cfg.bad_v ||
			v == cur_cfg.rsv_v;
	endfunction

	function automatic logic [15:0] random_mark();
		case ($urandom_range(3))
			0: return cur_cfg.free_v;
			1: return cur_cfg.end_v;
			2: return cur_cfg.bad_v;
			default: return cur_cfg.rsv_v;
		endcase
	endfunction

	function automatic logic [15:0] random_loaded();
		return loaded_q[$urandom_range(loaded_q.size() - 1)];
	endfunction

	// A table value that keeps every walk on loaded entries: a mark or a loaded cluster.
	function automatic logic [15:0] pick_link();
		if (loaded_q.size() == 0 || $urandom_range(1) == 0) return random_mark();
		return random_loaded();
	endfunction

	// Item with every field random; the caller fills in what the mode uses.
	function automatic in_item_t rand_item(input logic [1:0] m);
		in_item_t it;
		it.mode = m;
		it.table_index = 16'($urandom);
		it.table_value = 16'($urandom);
		it.first_cluster = 16'($urandom);
		it.file_length = $urandom;
		return it;
	endfunction

	function automatic logic [31:0] pick_length(input int clusters);
		logic [31:0] span;
		span = 32'(spc_eff()) * 32'(cur_cfg.sbytes);
		case ($urandom_range(4))
			0: return '0;
			1: return 32'($urandom_range(3)) * 32'(cur_cfg.sbytes) + 32'($urandom_range(1));
			2: return span * 32'($urandom_range(1, clusters));
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	// Offer one item and hold it until the block takes it.
	task automatic send_item(input in_item_t it);
		while ($urandom_range(99) < tx_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.data <= it;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
		if (it.mode != MODE_UNUSED) accepted++;
		// Idle pattern by progress: sender light, then receiver light, then none.
		if (accepted < TOTAL_ITEMS / 3) begin
			tx_idle_pct = 8;
			rx_idle_pct = 57;
		end else if (accepted < 2 * TOTAL_ITEMS / 3) begin
			tx_idle_pct = 57;
			rx_idle_pct = 8;
		end else begin
			tx_idle_pct = 0;
			rx_idle_pct = 0;
		end
	endtask

	task automatic load_entry(input logic [15:0] idx, input logic [15:0] val);
		in_item_t it;
		it = rand_item(MODE_LOAD);
		it.table_index = idx;
		it.table_value = val;
		send_item(it);
		if (!loaded[idx]) loaded_q = {loaded_q, idx};
		loaded[idx] = 1'b1;
		shadow[idx] = val;
	endtask

	task automatic start_walk(input logic [15:0] first, input logic [31:0] len);
		in_item_t it;
		it = rand_item(MODE_START);
		it.first_cluster = first;
		it.file_length = len;
		send_item(it);
	endtask

	task automatic request_next();
		send_item(rand_item(MODE_NEXT));
	endtask

	// Wait until every expected result is in and the block has gone quiet.
	task automatic settle();
		cmd_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apply_setting(input walk_cfg_t c);
		reg_write(REG_DATA_OFFSET, c.base);
		reg_write(REG_SPC, 32'(c.spc));
		reg_write(REG_SECTOR_BYTES, 32'(c.sbytes));
		reg_write(REG_FREE_MARK, 32'(c.free_v));
		reg_write(REG_END_MARK, 32'(c.end_v));
		reg_write(REG_BAD_MARK, 32'(c.bad_v));
		reg_write(REG_RSV_MARK, 32'(c.rsv_v));
		cfg_we <= 1'b0;
		cur_cfg = c;
	endtask

	task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	// New marks can turn an old terminator into a link to an unloaded cluster; re-terminate.
	task automatic repair_links();
		foreach (loaded_q[i]) begin
			if (!is_mark(shadow[loaded_q[i]]) && !loaded[shadow[loaded_q[i]]]) begin
				load_entry(loaded_q[i], random_mark());
			end
		end
	endtask

	// Corner cases, run with one sector per cluster so that every next item crosses a cluster.
	task automatic directed_checks();
		request_next();
		send_item(rand_item(MODE_UNUSED));
		load_entry(16'hFFFF, cur_cfg.end_v);
		load_entry(16'h0000, cur_cfg.bad_v);
		load_entry(16'h0001, cur_cfg.free_v);
		load_entry(16'h0002, 16'h0003);
		load_entry(16'h0003, cur_cfg.rsv_v);
		// Zero length still yields the first sector; cluster zero wraps the address.
		start_walk(16'h0000, '0);
		request_next();
		start_walk(16'h0001, '1);
		request_next();
		start_walk(16'h0000, '1);
		request_next();
		// The size limit ends the walk even though the link is a real cluster.
		start_walk(16'h0002, 32'(cur_cfg.sbytes));
		request_next();
		// A start in the middle of a walk restarts from the new file.
		start_walk(16'h0002, '1);
		request_next();
		start_walk(16'hFFFF, '1);
		request_next();
		start_walk(16'h0002, '1);
		request_next();
		request_next();
		request_next();
	endtask

	// Build a short chain back to front, start a file on it and read some sectors.
	task automatic walk_chain();
		logic [15:0] links [4];
		logic [15:0] tail;
		int          count;
		int          reads;
		count = $urandom_range(1, 4);
		for (int k = 0; k < count; k++) begin
			if (loaded_q.size() > 0 && $urandom_range(3) == 0) begin
				links[k] = random_loaded();
			end else begin
				links[k] = 16'($urandom);
			end
		end
		tail = random_mark();
		if (loaded_q.size() > 0 && $urandom_range(4) == 0) tail = random_loaded();
		load_entry(links[count - 1], tail);
		for (int k = count - 2; k >= 0; k--) load_entry(links[k], links[k + 1]);
		start_walk(links[0], pick_length(count));
		reads = count * spc_eff() + 2;
		if (reads > MAX_NEXT_RUN) reads = MAX_NEXT_RUN;
		repeat ($urandom_range(1, reads)) request_next();
	endtask

	// Mostly well-formed chains; the rest is loose loads, reads, restarts and unused modes.
	task automatic random_burst();
		int pick;
		pick = $urandom_range(99);
		if (pick < 70) begin
			walk_chain();
		end else if (pick < 80) begin
			load_entry(16'($urandom), pick_link());
		end else if (pick < 90) begin
			request_next();
		end else if (pick < 97) begin
			if (loaded_q.size() > 0) start_walk(random_loaded(), pick_length(1));
		end else begin
			send_item(rand_item(MODE_UNUSED));
		end
	endtask

	// Main sequence: reset, corner cases, then one random phase for each of the other register settings.
	initial begin
		cmd_ch.valid <= 1'b0;
		cmd_ch.data <= '0;
		cfg_we <= 1'b0;
		cfg_idx <= REG_DATA_OFFSET;
		cfg_wdata <= '0;
		arst_n <= 1'b0;
		cur_cfg = setting_for(SETTING_COUNT - 1);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		apply_setting(setting_for(0));
		directed_checks();
		for (int p = 1; p < SETTING_COUNT; p++) begin
			settle();
			apply_setting(setting_for(p));
			repair_links();
			if (p == 1 || p == 4) hold_requests++;
			while (accepted < p * TOTAL_ITEMS / (SETTING_COUNT - 1)) random_burst();
		end
		settle();
		if (mismatches == 0) begin
			$display("fat16_chain_sector_walker_core_test: done, clean");
		end else begin
			$display("fat16_chain_sector_walker_core_test: done, errors");
		end
		$finish;
	end
endmodule

[files.f]
+incdir+rtl
rtl/fat16w_pkg.sv
rtl/fat16w_chan_if.sv
rtl/fat16w_table.sv
rtl/fat16_chain_sector_walker_core.sv
tb/fat16w_walk_checker.sv
tb/fat16_chain_sector_walker_core_test.sv
